[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[hdl/jsu_pkg.sv]
// ---------------------------------------------------------------------------
// jsu_pkg
// types and constants of the json string unescape decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsu_pkg;

    typedef enum logic [3:0] {
        MODE_PLAIN = 4'd0,
        MODE_ESC   = 4'd1,
        MODE_HEX1  = 4'd2,
        MODE_HEX2  = 4'd3,
        MODE_HEX3  = 4'd4,
        MODE_HEX4  = 4'd5,
        MODE_SBS   = 4'd6,
        MODE_SU    = 4'd7,
        MODE_LOW1  = 4'd8,
        MODE_LOW2  = 4'd9,
        MODE_LOW3  = 4'd10,
        MODE_LOW4  = 4'd11
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    localparam int MAX_RESULTS = 4;

    // decoder state carried between bytes
    typedef struct packed {
        t_mode       mode;
        logic [15:0] accum;
        logic [15:0] high;
    } t_state;

    // results caused by one input byte, slot 0 goes out first
    typedef struct packed {
        logic [2:0]                   cnt;
        t_kind                        kind;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
    } t_group;

endpackage

[hdl/jsu_in_if.sv]
// ---------------------------------------------------------------------------
// jsu_in_if
// raw byte channel into the decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

[hdl/jsu_out_if.sv]
// ---------------------------------------------------------------------------
// jsu_out_if
// decoded result channel out of the decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

[hdl/jsu_decode.sv]
// ---------------------------------------------------------------------------
// jsu_decode
// combinational step: one raw byte plus current state to next state and results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_decode
    import jsu_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output t_state     o_next,
    output t_group     o_grp
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    // {ok, value} of a hex digit in either case
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    // {ok, byte} of a single-letter escape
    function automatic logic [8:0] esc_map(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    logic [4:0]  hex;
    logic        hex_ok;
    logic [15:0] acc_nxt;
    logic [8:0]  esc;
    logic        surrogate;
    logic [15:0] hi_off;
    logic [25:0] full;

    assign hex       = hex_digit(i_byte);
    assign hex_ok    = hex[4];
    assign acc_nxt   = {i_state.accum[11:0], hex[3:0]};
    assign esc       = esc_map(i_byte);
    assign surrogate = (acc_nxt[15:11] == 5'b11011);
    // low 26 bits of the pair sum are all the output bytes need
    assign hi_off    = i_state.high - 16'hD800;
    assign full      = 26'h0010000 + {hi_off, 10'd0}
                     + {10'd0, acc_nxt} - 26'h000DC00;

    // next state
    always_comb begin
        o_next = i_state;
        if (i_eot) begin
            o_next.mode  = MODE_PLAIN;
            o_next.accum = 16'd0;
        end else begin
            unique case (i_state.mode)
                MODE_ESC: begin
                    if (i_byte == CH_U) begin
                        o_next.mode  = MODE_HEX1;
                        o_next.accum = 16'd0;
                    end else begin
                        o_next.mode = MODE_PLAIN;
                        if (!esc[8]) o_next.accum = 16'd0;
                    end
                end
                MODE_HEX1, MODE_HEX2, MODE_HEX3,
                MODE_LOW1, MODE_LOW2, MODE_LOW3: begin
                    if (hex_ok) begin
                        o_next.accum = acc_nxt;
                        o_next.mode  = t_mode'(i_state.mode + 4'd1);
                    end else begin
                        o_next.mode  = MODE_PLAIN;
                        o_next.accum = 16'd0;
                    end
                end
                MODE_HEX4: begin
                    o_next.accum = 16'd0;
                    o_next.mode  = MODE_PLAIN;
                    if (hex_ok && surrogate) begin
                        o_next.high = acc_nxt;
                        o_next.mode = MODE_SBS;
                    end
                end
                MODE_SBS: begin
                    if (i_byte == CH_BSL) begin
                        o_next.mode = MODE_SU;
                    end else begin
                        o_next.mode  = MODE_PLAIN;
                        o_next.accum = 16'd0;
                    end
                end
                MODE_SU: begin
                    o_next.accum = 16'd0;
                    o_next.mode  = (i_byte == CH_U) ? MODE_LOW1 : MODE_PLAIN;
                end
                MODE_LOW4: begin
                    o_next.accum = 16'd0;
                    o_next.mode  = MODE_PLAIN;
                end
                default: begin
                    // plain mode, unused codes behave the same
                    o_next.mode = (i_byte == CH_BSL) ? MODE_ESC : MODE_PLAIN;
                end
            endcase
        end
    end

    // results
    always_comb begin
        o_grp.cnt   = 3'd0;
        o_grp.kind  = KIND_BYTE;
        o_grp.bytes = '0;
        if (i_eot) begin
            o_grp.cnt  = 3'd1;
            o_grp.kind = KIND_ERR;
        end else begin
            unique case (i_state.mode)
                MODE_ESC: begin
                    if (esc[8]) begin
                        o_grp.cnt      = 3'd1;
                        o_grp.bytes[0] = esc[7:0];
                    end else if (i_byte != CH_U) begin
                        o_grp.cnt  = 3'd1;
                        o_grp.kind = KIND_ERR;
                    end
                end
                MODE_HEX1, MODE_HEX2, MODE_HEX3,
                MODE_LOW1, MODE_LOW2, MODE_LOW3: begin
                    if (!hex_ok) begin
                        o_grp.cnt  = 3'd1;
                        o_grp.kind = KIND_ERR;
                    end
                end
                MODE_HEX4: begin
                    if (!hex_ok) begin
                        o_grp.cnt  = 3'd1;
                        o_grp.kind = KIND_ERR;
                    end else if (acc_nxt < 16'h0080) begin
                        o_grp.cnt      = 3'd1;
                        o_grp.bytes[0] = acc_nxt[7:0];
                    end else if (acc_nxt < 16'h0800) begin
                        o_grp.cnt      = 3'd2;
                        o_grp.bytes[0] = 8'hC0 | {3'd0, acc_nxt[10:6]};
                        o_grp.bytes[1] = 8'h80 | {2'd0, acc_nxt[5:0]};
                    end else if (!surrogate) begin
                        o_grp.cnt      = 3'd3;
                        o_grp.bytes[0] = 8'hE0 | {4'd0, acc_nxt[15:12]};
                        o_grp.bytes[1] = 8'h80 | {2'd0, acc_nxt[11:6]};
                        o_grp.bytes[2] = 8'h80 | {2'd0, acc_nxt[5:0]};
                    end
                end
                MODE_SBS: begin
                    if (i_byte != CH_BSL) begin
                        o_grp.cnt  = 3'd1;
                        o_grp.kind = KIND_ERR;
                    end
                end
                MODE_SU: begin
                    if (i_byte != CH_U) begin
                        o_grp.cnt  = 3'd1;
                        o_grp.kind = KIND_ERR;
                    end
                end
                MODE_LOW4: begin
                    if (!hex_ok) begin
                        o_grp.cnt  = 3'd1;
                        o_grp.kind = KIND_ERR;
                    end else begin
                        // lead byte truncates to 8 bits, no range check
                        o_grp.cnt      = 3'd4;
                        o_grp.bytes[0] = 8'hF0 | full[25:18];
                        o_grp.bytes[1] = 8'h80 | {2'd0, full[17:12]};
                        o_grp.bytes[2] = 8'h80 | {2'd0, full[11:6]};
                        o_grp.bytes[3] = 8'h80 | {2'd0, full[5:0]};
                    end
                end
                default: begin
                    if (i_byte == CH_QUOTE) begin
                        o_grp.cnt  = 3'd1;
                        o_grp.kind = KIND_DONE;
                    end else if (i_byte != CH_BSL) begin
                        o_grp.cnt      = 3'd1;
                        o_grp.bytes[0] = i_byte;
                    end
                end
            endcase
        end
    end

endmodule

[hdl/json_string_unescape_utf8.sv]
// ---------------------------------------------------------------------------
// json_string_unescape_utf8
// streaming decoder of a json string body with escapes and utf-8 output
// ---------------------------------------------------------------------------
// One raw byte is taken per cycle and decoded in the same cycle into a result
// group register holding up to four results; results leave one per cycle
// while the receiver is ready. A byte is taken whenever the group is empty or
// its final result is leaving, so bytes giving zero or one result flow at one
// per cycle while the receiver is ready. A byte giving several results (a \u
// escape end: two or three bytes, a surrogate pair: four) holds the input
// while the group register drains. No clearing pass after reset.
`timescale 1ns / 1ps

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

`include "assert_macros.svh"

    t_state r_state;
    t_state n_state;
    t_group grp;

    logic [MAX_RESULTS-1:0][7:0] r_bytes;
    t_kind                       r_kind;
    logic [2:0]                  r_cnt, n_cnt;
    logic [1:0]                  r_idx, n_idx;

    logic in_fire;
    logic out_fire;

    jsu_decode u_decode (
        .i_state (r_state),
        .i_byte  (i_in.in_byte),
        .i_eot   (i_in.end_of_text),
        .o_next  (n_state),
        .o_grp   (grp)
    );

    assign i_in.ready     = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_out.ready);
    assign in_fire        = i_in.valid && i_in.ready;
    assign out_fire       = o_out.valid && o_out.ready;

    assign o_out.valid    = (r_cnt != 3'd0);
    assign o_out.out_byte = r_bytes[r_idx];
    assign o_out.kind     = r_kind;
    assign o_out.last     = (r_cnt == 3'd1);

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (out_fire) begin
            n_cnt = r_cnt - 3'd1;
            n_idx = r_idx + 2'd1;
        end
        // a new request replaces a group that is empty or just finishing
        if (in_fire) begin
            n_cnt = grp.cnt;
            n_idx = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode  <= MODE_PLAIN;
            r_state.accum <= 16'd0;
            r_state.high  <= 16'd0;
            r_cnt         <= 3'd0;
            r_idx         <= 2'd0;
        end else begin
            if (in_fire) r_state <= n_state;
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_bytes <= grp.bytes;
            r_kind  <= grp.kind;
        end
    end

    `ASSERT_SYNC(a_slot_range, i_clk, i_rst_n, ({2'd0, r_idx} + {1'b0, r_cnt}) <= 4'd4, "result slot past group end")
    `ASSERT_SYNC(a_status_single, i_clk, i_rst_n, (r_cnt != 3'd0 && r_kind != KIND_BYTE) |-> (r_cnt == 3'd1 && r_idx == 2'd0), "done or error not alone in group")
    `ASSERT_SYNC(a_drain_step, i_clk, i_rst_n, (out_fire && r_cnt > 3'd1) |=> (r_cnt == $past(r_cnt) - 3'd1), "group did not drain by one")

endmodule

[sim/json_string_unescape_utf8_tb.sv]
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// self-checking bench for the json string unescape decoder
// ---------------------------------------------------------------------------
// A short table of hand-picked bytes is followed by random string bodies built
// from plain bytes, simple escapes, \u units, surrogate pairs, quotes, end of
// text and broken escapes. A behavioral decoder predicts each result that no
// table entry gives itself; each result leaving the block is compared field
// by field with the oldest prediction. Sender gaps and receiver stalls vary
// per phase. Once, the receiver holds off for a long stretch.
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    localparam int HOLD_CYCLES     = 120;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int DIR_N           = 30;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int PRINT_LIMIT     = 40;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_Q      = 8'h71;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_UC_G   = 8'h47;

    localparam logic [7:0][7:0] ESC_LETTERS =
        {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    localparam logic [7:0][15:0] UNIT_EDGES =
        {16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
        logic       typed;
        logic [7:0] tb;
        t_kind      tk;
    } t_raw_req;

    typedef struct {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_dec_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jsu_in_if  in_if ();
    jsu_out_if out_if ();

    json_string_unescape_utf8 u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // decoder state of the predictor
    t_mode       pm    = MODE_PLAIN;
    logic [15:0] pacc  = 16'h0000;
    logic [15:0] phigh = 16'h0000;

    t_dec_result decoded_q [$];
    t_raw_req    stim_q [$];
    t_raw_req    directed_tbl [DIR_N];
    t_raw_req    cur_req;
    int          fail_count    = 0;
    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    logic        hold_go       = 1'b0;
    logic        rx_hold       = 1'b0;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    // advance the predicted decoder by one byte, returns the result count
    function automatic int unescape_step(input logic [7:0] c, input logic eot,
                                         output logic [3:0][7:0] ob, output t_kind k);
        int          n;
        int          h;
        logic [15:0] cp;
        logic [31:0] full;
        logic        bad;
        n   = 0;
        ob  = '0;
        k   = KIND_BYTE;
        bad = 1'b0;
        if (eot) begin
            bad = 1'b1;
        end else begin
            case (pm)
                MODE_PLAIN: begin
                    if (c == CH_QUOTE) begin
                        k = KIND_DONE;
                        n = 1;
                    end else if (c == CH_BSLASH) begin
                        pm = MODE_ESC;
                    end else begin
                        ob[0] = c;
                        n     = 1;
                    end
                end
                MODE_ESC: begin
                    pm = MODE_PLAIN;
                    n  = 1;
                    case (c)
                        CH_QUOTE:  ob[0] = CH_QUOTE;
                        CH_BSLASH: ob[0] = CH_BSLASH;
                        CH_SLASH:  ob[0] = CH_SLASH;
                        CH_B:      ob[0] = 8'h08;
                        CH_F:      ob[0] = 8'h0C;
                        CH_N:      ob[0] = 8'h0A;
                        CH_R:      ob[0] = 8'h0D;
                        CH_T:      ob[0] = 8'h09;
                        CH_U: begin
                            pm   = MODE_HEX1;
                            pacc = 16'h0000;
                            n    = 0;
                        end
                        default: bad = 1'b1;
                    endcase
                end
                MODE_SBS: begin
                    if (c != CH_BSLASH) bad = 1'b1;
                    else pm = MODE_SU;
                end
                MODE_SU: begin
                    if (c != CH_U) begin
                        bad = 1'b1;
                    end else begin
                        pm   = MODE_LOW1;
                        pacc = 16'h0000;
                    end
                end
                default: begin
                    h = hex_nibble(c);
                    if (h < 0) begin
                        bad = 1'b1;
                    end else begin
                        pacc = {pacc[11:0], h[3:0]};
                        if (pm == MODE_HEX4) begin
                            cp = pacc;
                            if (cp < 16'h0080) begin
                                ob[0] = cp[7:0];
                                n     = 1;
                            end else if (cp < 16'h0800) begin
                                ob[0] = {3'b110, cp[10:6]};
                                ob[1] = {2'b10, cp[5:0]};
                                n     = 2;
                            end else if (cp < 16'hD800 || cp >= 16'hE000) begin
                                ob[0] = {4'hE, cp[15:12]};
                                ob[1] = {2'b10, cp[11:6]};
                                ob[2] = {2'b10, cp[5:0]};
                                n     = 3;
                            end
                            pacc = 16'h0000;
                            if (n == 0) begin
                                // first half of a surrogate pair
                                phigh = cp;
                                pm    = MODE_SBS;
                            end else begin
                                pm = MODE_PLAIN;
                            end
                        end else if (pm == MODE_LOW4) begin
                            // 32-bit wrap, no range check on the low unit
                            full = 32'h10000 + (32'(phigh) - 32'hD800) * 32'h400
                                   + (32'(pacc) - 32'hDC00);
                            ob[0] = 8'hF0 | full[25:18];
                            ob[1] = {2'b10, full[17:12]};
                            ob[2] = {2'b10, full[11:6]};
                            ob[3] = {2'b10, full[5:0]};
                            n     = 4;
                            pacc  = 16'h0000;
                            pm    = MODE_PLAIN;
                        end else begin
                            pm = t_mode'(pm + 4'd1);
                        end
                    end
                end
            endcase
        end
        if (bad) begin
            pm    = MODE_PLAIN;
            pacc  = 16'h0000;
            ob    = '0;
            k     = KIND_ERR;
            n     = 1;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic add_expected(input logic [7:0] d, input t_kind k, input logic l);
        t_dec_result e;
        e.data = d;
        e.kind = k;
        e.last = l;
        decoded_q.insert(decoded_q.size(), e);
    endtask

    task automatic take_request(input t_raw_req r);
        logic [3:0][7:0] ob;
        t_kind           k;
        int              n;
        n = unescape_step(r.b, r.eot, ob, k);
        if (r.typed) begin
            add_expected(r.tb, r.tk, 1'b1);
        end else begin
            for (int i = 0; i < n; i++)
                add_expected(ob[i], k, (i == n - 1));
        end
    endtask

    task automatic check_result();
        t_dec_result want;
        if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h kind %0d",
                                      out_if.out_byte, out_if.kind));
        end else begin
            want = decoded_q.pop_front();
            if (out_if.out_byte !== want.data)
                report_mismatch($sformatf("out_byte %02h, want %02h",
                                          out_if.out_byte, want.data));
            if (out_if.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", out_if.kind, want.kind));
            if (out_if.last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", out_if.last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) take_request(cur_req);
            if (out_if.valid && out_if.ready) check_result();
        end
    end

    // receiver
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= !rx_hold && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // one long receiver hold-off, counted here
    initial begin
        wait (hold_go);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CH_ZERO + v;
        return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + v - 8'd10;
    endfunction

    task automatic push_plain(input logic [7:0] b, input logic eot);
        t_raw_req r;
        r = '{b, eot, 1'b0, 8'h00, KIND_BYTE};
        stim_q.insert(stim_q.size(), r);
    endtask

    task automatic push_unit(input logic [15:0] v);
        push_plain(CH_BSLASH, 1'b0);
        push_plain(CH_U, 1'b0);
        for (int k = 3; k >= 0; k--) push_plain(hex_char(v[4*k +: 4]), 1'b0);
    endtask

    task automatic add_random_piece();
        int          sel;
        int          m;
        logic [7:0]  c;
        logic [15:0] u;
        logic        bad;
        sel = $urandom_range(99);
        if (sel < 28) begin
            push_plain(8'($urandom_range(255)), 1'b0);
        end else if (sel < 42) begin
            push_plain(CH_BSLASH, 1'b0);
            push_plain(ESC_LETTERS[3'($urandom_range(7))], 1'b0);
        end else if (sel < 62) begin
            case ($urandom_range(4))
                0:       u = UNIT_EDGES[3'($urandom_range(7))];
                1:       u = 16'($urandom_range(16'h007F));
                2:       u = 16'($urandom_range(16'h0080, 16'h07FF));
                3:       u = 16'($urandom_range(16'h0800, 16'hD7FF));
                default: u = 16'($urandom_range(16'hE000, 16'hFFFF));
            endcase
            push_unit(u);
        end else if (sel < 76) begin
            push_unit(16'($urandom_range(16'hD800, 16'hDFFF)));
            if ($urandom_range(4) == 0) push_unit(16'($urandom_range(16'hFFFF)));
            else push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else if (sel < 81) begin
            push_plain(CH_QUOTE, 1'b0);
        end else if (sel < 86) begin
            push_plain(8'($urandom_range(255)), 1'b1);
        end else if (sel < 91) begin
            // \u cut short by a non-hex byte or end of text
            push_plain(CH_BSLASH, 1'b0);
            push_plain(CH_U, 1'b0);
            m = $urandom_range(3);
            for (int k = 0; k < m; k++) push_plain(hex_char(4'($urandom_range(15))), 1'b0);
            if ($urandom_range(3) == 0) begin
                push_plain(8'($urandom_range(255)), 1'b1);
            end else begin
                do c = 8'($urandom_range(255)); while (hex_nibble(c) >= 0);
                push_plain(c, 1'b0);
            end
        end else if (sel < 95) begin
            // unknown escape letter
            do begin
                c   = 8'($urandom_range(255));
                bad = (c == CH_U);
                for (int k = 0; k < 8; k++) if (c == ESC_LETTERS[k]) bad = 1'b1;
            end while (bad);
            push_plain(CH_BSLASH, 1'b0);
            push_plain(c, 1'b0);
        end else begin
            // high unit whose second escape never comes
            push_unit(16'($urandom_range(16'hD800, 16'hDFFF)));
            if ($urandom_range(1)) begin
                do c = 8'($urandom_range(255)); while (c == CH_BSLASH);
                push_plain(c, 1'b0);
            end else begin
                do c = 8'($urandom_range(255)); while (c == CH_U);
                push_plain(CH_BSLASH, 1'b0);
                push_plain(c, 1'b0);
            end
        end
    endtask

    task automatic send_request(input t_raw_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_req = r;
        in_if.valid       <= 1'b1;
        in_if.in_byte     <= r.b;
        in_if.end_of_text <= r.eot;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    initial begin
        int src_pct [4];
        int snk_pct [4];
        int w;
        src_pct = '{0, 46, 0, 31};
        snk_pct = '{0, 0, 46, 31};
        directed_tbl = '{
            '{8'h00,     1'b0, 1'b1, 8'h00, KIND_BYTE},   // extremes right after reset
            '{8'hFF,     1'b0, 1'b1, 8'hFF, KIND_BYTE},
            '{CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{CH_N,      1'b0, 1'b1, 8'h0A, KIND_BYTE},
            '{CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},   // unknown escape letter
            '{CH_Q,      1'b0, 1'b1, 8'h00, KIND_ERR},
            '{CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},   // surrogate pair
            '{CH_U,      1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"D",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"8",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"3",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"D",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{CH_U,      1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"d",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"e",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"0",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"0",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},   // bad hex digit
            '{CH_U,      1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{CH_UC_G,   1'b0, 1'b1, 8'h00, KIND_ERR},
            '{CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},   // missing second escape
            '{CH_U,      1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"D",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"8",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"0",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{"0",       1'b0, 1'b0, 8'h00, KIND_BYTE},
            '{CH_X,      1'b0, 1'b1, 8'h00, KIND_ERR},
            '{CH_QUOTE,  1'b0, 1'b1, 8'h00, KIND_DONE},
            '{8'hFF,     1'b1, 1'b1, 8'h00, KIND_ERR}    // end of text
        };

        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.in_byte     = 8'h00;
        in_if.end_of_text = 1'b0;
        cur_req           = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int j = 0; j < DIR_N; j++) send_request(directed_tbl[j]);

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = src_pct[ph];
            snk_stall_pct <= snk_pct[ph];
            // sender keeps offering while the receiver is held off
            if (ph == 0) hold_go = 1'b1;
            stim_q.delete();
            while (stim_q.size() < ITEMS_PER_PHASE) add_random_piece();
            foreach (stim_q[j]) send_request(stim_q[j]);
        end
        in_if.valid <= 1'b0;

        w = 0;
        while (w < DRAIN_LIMIT && decoded_q.size() != 0) begin
            @(posedge i_clk);
            w++;
        end
        repeat (16) @(posedge i_clk);
        if (decoded_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_in_if.sv
hdl/jsu_out_if.sv
hdl/jsu_decode.sv
hdl/json_string_unescape_utf8.sv
sim/json_string_unescape_utf8_tb.sv
